@@ hdl/nfs4a_pkg.sv @@
// Shared types and constants for the NFS4 ACL XDR parser.
package nfs4a_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	// one output beat
	typedef struct packed {
		kind_t       kind;
		logic [9:0]  index;
		logic [31:0] etype;
		logic [31:0] eflags;
		logic [31:0] emask;
		logic [10:0] who_len;
		logic [7:0]  who_byte;
		status_t     status;
		logic [10:0] total;
		logic        last;
	} beat_t;

	// everything one accepted item produces: an optional header or name beat,
	// then an optional status beat
	typedef struct packed {
		logic        has_pri;
		beat_t       pri;
		logic        has_st;
		status_t     st_status;
		logic [10:0] st_total;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t data;
	} q_wr_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} q_rd_t;

endpackage

@@ hdl/nfs4_acl_xdr_parser.sv @@
// NFS4 ACL XDR byte-stream parser, top level.
//
//  channel | dir | handshake             | beat
//  in      | in  | in_valid / in_stall   | data_byte, byte_present, end_of_buffer
//  out     | out | out_valid / out_stall | result_kind .. last_result
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input beat per cycle unless in_stall is high; the parse state machine acts on
// each accepted byte. An item yields at most two result beats; the output stage
// sends one beat per cycle unless out_stall holds it. A four-entry queue parts the
// parser from the output register, so input stalls only when that queue is full.
// Reset clears parse state and loads the limits from the parameters; no clearing pass.
module nfs4_acl_xdr_parser #(
	parameter int unsigned BUFFER_BYTE_LIMIT = 65536,
	parameter int unsigned ENTRY_LIMIT       = 1024,
	parameter int unsigned NAME_LIMIT        = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [9:0]  entry_index,
	output logic [31:0] entry_type,
	output logic [31:0] entry_flags,
	output logic [31:0] entry_mask,
	output logic [10:0] who_length,
	output logic [7:0]  who_byte,
	output logic [1:0]  status,
	output logic [10:0] entry_total,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import nfs4a_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;
	beat_t beat;

	nfs4a_front #(
		.BUFFER_BYTE_LIMIT(BUFFER_BYTE_LIMIT),
		.ENTRY_LIMIT      (ENTRY_LIMIT),
		.NAME_LIMIT       (NAME_LIMIT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.queue_full   (q_full),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.end_of_buffer(end_of_buffer),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_wr         (q_wr)
	);

	nfs4a_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_wr  (q_wr),
		.full  (q_full),
		.q_rd  (q_rd),
		.pop   (q_pop)
	);

	nfs4a_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.beat     (beat)
	);

	assign in_stall    = q_full;
	assign result_kind = beat.kind;
	assign entry_index = beat.index;
	assign entry_type  = beat.etype;
	assign entry_flags = beat.eflags;
	assign entry_mask  = beat.emask;
	assign who_length  = beat.who_len;
	assign who_byte    = beat.who_byte;
	assign status      = beat.status;
	assign entry_total = beat.total;
	assign last_result = beat.last;

endmodule

@@ hdl/nfs4a_front.sv @@
// Front end: config registers, byte acceptance and XDR parse state machine.
module nfs4a_front #(
	parameter int unsigned BUFFER_BYTE_LIMIT = 65536,
	parameter int unsigned ENTRY_LIMIT       = 1024,
	parameter int unsigned NAME_LIMIT        = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 queue_full,
	input  logic [7:0]           data_byte,
	input  logic                 byte_present,
	input  logic                 end_of_buffer,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [16:0]          cfg_data,
	output nfs4a_pkg::q_wr_t     q_wr
);
	import nfs4a_pkg::*;

	localparam logic [1:0] CFG_MAX_BUF   = 2'd0;
	localparam logic [1:0] CFG_MAX_ENTRY = 2'd1;
	localparam logic [1:0] CFG_MAX_WHO   = 2'd2;

	localparam logic [16:0] RST_MAX_BUF =
		(BUFFER_BYTE_LIMIT > 131071) ? 17'h1FFFF : 17'(BUFFER_BYTE_LIMIT);
	localparam logic [10:0] RST_MAX_ENTRY =
		(ENTRY_LIMIT > 2047) ? 11'h7FF : 11'(ENTRY_LIMIT);
	localparam logic [10:0] RST_MAX_WHO =
		(NAME_LIMIT > 2047) ? 11'h7FF : 11'(NAME_LIMIT);

	localparam logic [17:0] BYTE_CAP = 18'h20000;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_HEADER,
		PH_NAME,
		PH_PAD,
		PH_DONE,
		PH_STOP
	} phase_t;

	logic [16:0] max_buf_q;
	logic [10:0] max_entry_q;
	logic [10:0] max_who_q;

	phase_t      phase_q, phase_d;
	logic [17:0] byte_total_q, byte_total_d;
	logic [23:0] word_q, word_d;
	logic [1:0]  byte_pos_q, byte_pos_d;
	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic [10:0] expected_q, expected_d;
	logic [10:0] done_q, done_d;
	logic [31:0] type_q, type_d;
	logic [31:0] flags_q, flags_d;
	logic [31:0] mask_q, mask_d;
	logic [10:0] name_left_q, name_left_d;
	logic [1:0]  pad_q, pad_d;
	status_t     err_q, err_d;
	logic        known_q, known_d;

	logic        accept;
	logic        fin;
	logic [31:0] word_full;
	logic [10:0] done_inc;
	bundle_t     bun;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !queue_full;
	assign word_full = {word_q, data_byte};
	assign done_inc  = 11'(done_q + 11'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_buf_q   <= RST_MAX_BUF;
			max_entry_q <= RST_MAX_ENTRY;
			max_who_q   <= RST_MAX_WHO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_BUF:   max_buf_q   <= cfg_data;
				CFG_MAX_ENTRY: max_entry_q <= cfg_data[10:0];
				CFG_MAX_WHO:   max_who_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d      = phase_q;
		byte_total_d = byte_total_q;
		word_d       = word_q;
		byte_pos_d   = byte_pos_q;
		hdr_pos_d    = hdr_pos_q;
		expected_d   = expected_q;
		done_d       = done_q;
		type_d       = type_q;
		flags_d      = flags_q;
		mask_d       = mask_q;
		name_left_d  = name_left_q;
		pad_d        = pad_q;
		err_d        = err_q;
		known_d      = known_q;
		fin          = 1'b0;
		bun          = '0;

		if (accept && byte_present) begin
			if (byte_total_q != BYTE_CAP)
				byte_total_d = 18'(byte_total_q + 18'd1);
			unique case (phase_q)
				PH_COUNT: begin
					word_d     = word_full[23:0];
					byte_pos_d = 2'(byte_pos_q + 2'd1);
					if (byte_pos_q == 2'd3) begin
						if (word_full > {21'd0, max_entry_q}) begin
							err_d   = ST_OVERFLOW;
							phase_d = PH_STOP;
						end else begin
							expected_d = word_full[10:0];
							done_d     = '0;
							known_d    = 1'b1;
							phase_d    = (word_full == 32'd0) ? PH_DONE : PH_HEADER;
						end
					end
				end
				PH_HEADER: begin
					word_d     = word_full[23:0];
					byte_pos_d = 2'(byte_pos_q + 2'd1);
					if (byte_pos_q == 2'd3) begin
						hdr_pos_d = 2'(hdr_pos_q + 2'd1);
						case (hdr_pos_q)
							2'd0: type_d  = word_full;
							2'd1: flags_d = word_full;
							2'd2: mask_d  = word_full;
							default: begin
								if (word_full > {21'd0, max_who_q}) begin
									err_d   = ST_OVERFLOW;
									phase_d = PH_STOP;
								end else begin
									name_left_d      = word_full[10:0];
									pad_d            = 2'(2'd0 - word_full[1:0]);
									bun.has_pri      = 1'b1;
									bun.pri.kind     = KIND_HEADER;
									bun.pri.index    = done_q[9:0];
									bun.pri.etype    = type_q;
									bun.pri.eflags   = flags_q;
									bun.pri.emask    = mask_q;
									bun.pri.who_len  = word_full[10:0];
									if (word_full != 32'd0)
										phase_d = PH_NAME;
									else if (pad_d != 2'd0)
										phase_d = PH_PAD;
									else
										fin = 1'b1;
								end
							end
						endcase
					end
				end
				PH_NAME: begin
					bun.has_pri      = 1'b1;
					bun.pri.kind     = KIND_NAME;
					bun.pri.index    = done_q[9:0];
					bun.pri.who_byte = data_byte;
					name_left_d      = 11'(name_left_q - 11'd1);
					if (name_left_q == 11'd1) begin
						if (pad_q != 2'd0)
							phase_d = PH_PAD;
						else
							fin = 1'b1;
					end
				end
				PH_PAD: begin
					pad_d = 2'(pad_q - 2'd1);
					if (pad_q == 2'd1)
						fin = 1'b1;
				end
				default: ;
			endcase

			if (fin) begin
				if (type_q > 32'd3) begin
					err_d   = ST_MALFORMED;
					phase_d = PH_STOP;
				end else begin
					done_d  = done_inc;
					phase_d = (done_inc == expected_q) ? PH_DONE : PH_HEADER;
				end
			end
		end

		if (accept && end_of_buffer) begin
			bun.has_st = 1'b1;
			if (byte_total_d < 18'd4)
				bun.st_status = ST_MALFORMED;
			else if (byte_total_d > {1'b0, max_buf_q})
				bun.st_status = ST_OVERFLOW;
			else if (err_d != ST_OK)
				bun.st_status = err_d;
			else if (phase_d != PH_DONE)
				bun.st_status = ST_MALFORMED;
			else
				bun.st_status = ST_OK;
			bun.st_total = known_d ? expected_d : 11'd0;

			phase_d      = PH_COUNT;
			byte_total_d = '0;
			word_d       = '0;
			byte_pos_d   = '0;
			hdr_pos_d    = '0;
			expected_d   = '0;
			done_d       = '0;
			type_d       = '0;
			flags_d      = '0;
			mask_d       = '0;
			name_left_d  = '0;
			pad_d        = '0;
			err_d        = ST_OK;
			known_d      = 1'b0;
		end
	end

	assign q_wr.push = accept && (bun.has_pri || bun.has_st);
	assign q_wr.data = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COUNT;
			byte_total_q <= '0;
			word_q       <= '0;
			byte_pos_q   <= '0;
			hdr_pos_q    <= '0;
			expected_q   <= '0;
			done_q       <= '0;
			type_q       <= '0;
			flags_q      <= '0;
			mask_q       <= '0;
			name_left_q  <= '0;
			pad_q        <= '0;
			err_q        <= ST_OK;
			known_q      <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			byte_total_q <= byte_total_d;
			word_q       <= word_d;
			byte_pos_q   <= byte_pos_d;
			hdr_pos_q    <= hdr_pos_d;
			expected_q   <= expected_d;
			done_q       <= done_d;
			type_q       <= type_d;
			flags_q      <= flags_d;
			mask_q       <= mask_d;
			name_left_q  <= name_left_d;
			pad_q        <= pad_d;
			err_q        <= err_d;
			known_q      <= known_d;
		end
	end

endmodule

@@ hdl/nfs4a_queue.sv @@
// Short FIFO of parsed item bundles between front end and output stage.
module nfs4a_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  nfs4a_pkg::q_wr_t  q_wr,
	output logic              full,
	output nfs4a_pkg::q_rd_t  q_rd,
	input  logic              pop
);
	import nfs4a_pkg::*;

	bundle_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.data  = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= q_wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				count_q <= (QPTR_W+1)'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= (QPTR_W+1)'(count_q - 1'b1);
		end
	end

endmodule

@@ hdl/nfs4a_back.sv @@
// Output stage: splits each bundle into beats and holds them in the output register.
module nfs4a_back (
	input  logic              clk,
	input  logic              arst_n,
	input  nfs4a_pkg::q_rd_t  q_rd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output nfs4a_pkg::beat_t  beat
);
	import nfs4a_pkg::*;

	logic  out_valid_q;
	logic  pri_sent_q;
	beat_t beat_q;
	beat_t next_beat;
	logic  last_part;
	logic  load;

	always_comb begin
		next_beat = '0;
		if (q_rd.data.has_pri && !pri_sent_q) begin
			next_beat = q_rd.data.pri;
			last_part = !q_rd.data.has_st;
		end else begin
			next_beat.kind   = KIND_STATUS;
			next_beat.status = q_rd.data.st_status;
			next_beat.total  = q_rd.data.st_total;
			next_beat.last   = 1'b1;
			last_part        = 1'b1;
		end
	end

	assign load = q_rd.valid && (!out_valid_q || !out_stall);
	assign pop  = load && last_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pri_sent_q  <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load)
				pri_sent_q <= !last_part;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			beat_q <= next_beat;
	end

	assign out_valid = out_valid_q;
	assign beat      = beat_q;

endmodule

@@ tb/sv/tb_nfs4_acl_xdr_parser.sv @@
// Testbench for the NFS4 ACL XDR parser: directed and random ACL buffers vs. a predictor.
`timescale 1ns / 100ps

module tb_nfs4_acl_xdr_parser;
	import nfs4a_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_PAD     = 8;
	localparam int unsigned END_PAD       = 16;
	localparam int unsigned BYTE_CAP      = 131072;
	localparam int unsigned TYPE_MAX      = 3;
	localparam int unsigned MISMATCH_SHOW = 10;

	localparam logic [1:0] REG_MAX_BUFFER  = 2'd0;
	localparam logic [1:0] REG_MAX_ENTRIES = 2'd1;
	localparam logic [1:0] REG_MAX_WHO     = 2'd2;
	localparam logic [1:0] REG_UNUSED      = 2'd3;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_HEADER,
		PH_NAME,
		PH_PAD,
		PH_DONE,
		PH_STOP
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        byte_present = 1'b0;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [9:0]  entry_index;
	logic [31:0] entry_type;
	logic [31:0] entry_flags;
	logic [31:0] entry_mask;
	logic [10:0] who_length;
	logic [7:0]  who_byte;
	logic [1:0]  status;
	logic [10:0] entry_total;
	logic        last_result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [16:0] cfg_data = 17'd0;

	nfs4_acl_xdr_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.byte_present  (byte_present),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.entry_index   (entry_index),
		.entry_type    (entry_type),
		.entry_flags   (entry_flags),
		.entry_mask    (entry_mask),
		.who_length    (who_length),
		.who_byte      (who_byte),
		.status        (status),
		.entry_total   (entry_total),
		.last_result   (last_result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	class acl_scoreboard;
		beat_t        due_beats[$];
		logic [16:0]  lim_buf;
		logic [10:0]  lim_ent;
		logic [10:0]  lim_who;
		parse_phase_t phase;
		int unsigned  byte_total;
		logic [31:0]  word_shift;
		logic [1:0]   word_pos;
		logic [1:0]   hdr_pos;
		logic [10:0]  ent_expected;
		logic [10:0]  ent_done;
		logic [31:0]  h_type;
		logic [31:0]  h_flags;
		logic [31:0]  h_mask;
		logic [10:0]  name_left;
		logic [1:0]   pad_left;
		status_t      err;
		bit           count_seen;
		int           mismatches;
		int           beats_checked;
		int           buffers;
		int           st_count[3];

		function new();
			lim_buf = 17'd65536;
			lim_ent = 11'd1024;
			lim_who = 11'd1024;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_COUNT;
			byte_total = 0;
			word_shift = '0;
			word_pos = '0;
			hdr_pos = '0;
			ent_expected = '0;
			ent_done = '0;
			h_type = '0;
			h_flags = '0;
			h_mask = '0;
			name_left = '0;
			pad_left = '0;
			err = ST_OK;
			count_seen = 1'b0;
		endfunction

		function void set_limit(logic [1:0] idx, logic [16:0] val);
			case (idx)
				REG_MAX_BUFFER: lim_buf = val;
				REG_MAX_ENTRIES: lim_ent = val[10:0];
				REG_MAX_WHO: lim_who = val[10:0];
				default: ;
			endcase
		endfunction

		function void halt(status_t code);
			err = code;
			phase = PH_STOP;
		endfunction

		function void close_entry();
			if (h_type > TYPE_MAX) begin
				halt(ST_MALFORMED);
				return;
			end
			ent_done = ent_done + 11'd1;
			phase = (ent_done == ent_expected) ? PH_DONE : PH_HEADER;
		endfunction

		function bit shift_in(logic [7:0] b);
			word_shift = {word_shift[23:0], b};
			word_pos = word_pos + 2'd1;
			return word_pos == 2'd0;
		endfunction

		function void decode_byte(logic [7:0] b);
			logic [31:0] w;
			beat_t bt;
			case (phase)
				PH_COUNT: begin
					if (!shift_in(b))
						return;
					w = word_shift;
					if (w > lim_ent) begin
						halt(ST_OVERFLOW);
						return;
					end
					ent_expected = w[10:0];
					ent_done = '0;
					count_seen = 1'b1;
					phase = (w == 0) ? PH_DONE : PH_HEADER;
				end
				PH_HEADER: begin
					if (!shift_in(b))
						return;
					w = word_shift;
					if (hdr_pos == 2'd3) begin
						hdr_pos = 2'd0;
						if (w > lim_who) begin
							halt(ST_OVERFLOW);
							return;
						end
						name_left = w[10:0];
						pad_left = 2'd0 - w[1:0];
						bt = '0;
						bt.kind = KIND_HEADER;
						bt.index = ent_done[9:0];
						bt.etype = h_type;
						bt.eflags = h_flags;
						bt.emask = h_mask;
						bt.who_len = w[10:0];
						bt.status = ST_OK;
						due_beats.push_back(bt);
						if (w != 0)
							phase = PH_NAME;
						else if (pad_left != 0)
							phase = PH_PAD;
						else
							close_entry();
					end else begin
						case (hdr_pos)
							2'd0: h_type = w;
							2'd1: h_flags = w;
							default: h_mask = w;
						endcase
						hdr_pos = hdr_pos + 2'd1;
					end
				end
				PH_NAME: begin
					bt = '0;
					bt.kind = KIND_NAME;
					bt.index = ent_done[9:0];
					bt.who_byte = b;
					bt.status = ST_OK;
					due_beats.push_back(bt);
					name_left = name_left - 11'd1;
					if (name_left == 0) begin
						if (pad_left != 0)
							phase = PH_PAD;
						else
							close_entry();
					end
				end
				PH_PAD: begin
					pad_left = pad_left - 2'd1;
					if (pad_left == 0)
						close_entry();
				end
				default: ;
			endcase
		endfunction

		function void absorb_item(logic [7:0] b, logic present, logic fin);
			status_t st;
			beat_t bt;
			if (present) begin
				if (byte_total < BYTE_CAP)
					byte_total++;
				decode_byte(b);
			end
			if (fin) begin
				if (byte_total < 4)
					st = ST_MALFORMED;
				else if (byte_total > lim_buf)
					st = ST_OVERFLOW;
				else if (err != ST_OK)
					st = err;
				else if (phase != PH_DONE)
					st = ST_MALFORMED;
				else
					st = ST_OK;
				bt = '0;
				bt.kind = KIND_STATUS;
				bt.status = st;
				bt.total = count_seen ? ent_expected : 11'd0;
				bt.last = 1'b1;
				due_beats.push_back(bt);
				st_count[st]++;
				buffers++;
				clear_parse();
			end
		endfunction

		function void match_beat(beat_t got);
			beat_t want;
			if (due_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOW)
					$display("unexpected beat: kind=%0d idx=%0d st=%0d last=%0b",
						got.kind, got.index, got.status, got.last);
				return;
			end
			want = due_beats.pop_front();
			beats_checked++;
			if (got.kind !== want.kind || got.index !== want.index ||
				got.etype !== want.etype || got.eflags !== want.eflags ||
				got.emask !== want.emask || got.who_len !== want.who_len ||
				got.who_byte !== want.who_byte || got.status !== want.status ||
				got.total !== want.total || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOW) begin
					$display("mismatch %0d exp: kind=%0d idx=%0d type=%h flags=%h mask=%h",
						mismatches, want.kind, want.index, want.etype, want.eflags,
						want.emask, " wlen=%0d wbyte=%h st=%0d tot=%0d last=%0b",
						want.who_len, want.who_byte, want.status, want.total, want.last);
					$display("mismatch %0d got: kind=%0d idx=%0d type=%h flags=%h mask=%h",
						mismatches, got.kind, got.index, got.etype, got.eflags,
						got.emask, " wlen=%0d wbyte=%h st=%0d tot=%0d last=%0b",
						got.who_len, got.who_byte, got.status, got.total, got.last);
				end
			end
		endfunction
	endclass

	acl_scoreboard sb;
	logic [7:0]    acl_bytes[$];
	bit            quiet = 1'b0;
	int            in_gap_odds = 0;
	int            bytes_sent = 0;
	int            items_sent = 0;
	int            settings = 0;
	int unsigned   cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.absorb_item(data_byte, byte_present, end_of_buffer);
	end

	always @(posedge clk) begin
		beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind_t'(result_kind);
			got.index = entry_index;
			got.etype = entry_type;
			got.eflags = entry_flags;
			got.emask = entry_mask;
			got.who_len = who_length;
			got.who_byte = who_byte;
			got.status = status_t'(status);
			got.total = entry_total;
			got.last = last_result;
			sb.match_beat(got);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
			sb.due_beats.size());
		$display("nfs4_acl_xdr_parser test failed");
		$finish;
	end

	// receiver back-pressure
	initial begin
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 120 : 20)) @(posedge clk);
			end
		end
	end

	function automatic void put_word(logic [31:0] w);
		acl_bytes.push_back(w[31:24]);
		acl_bytes.push_back(w[23:16]);
		acl_bytes.push_back(w[15:8]);
		acl_bytes.push_back(w[7:0]);
	endfunction

	function automatic void begin_acl(logic [31:0] count);
		acl_bytes.delete();
		put_word(count);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void put_entry(logic [31:0] t, logic [31:0] f, logic [31:0] m,
		logic [31:0] wl, int body);
		put_word(t);
		put_word(f);
		put_word(m);
		put_word(wl);
		repeat (body) acl_bytes.push_back(8'($urandom));
		repeat ((4 - body % 4) % 4) acl_bytes.push_back(8'($urandom));
	endfunction

	function automatic void make_random_acl();
		int shape;
		int n;
		int bad_j;
		int big_j;
		int cut;
		int body;
		int wide;
		logic [31:0] t;
		logic [31:0] wl;
		shape = $urandom_range(0, 99);
		acl_bytes.delete();
		if (shape >= 86 && shape < 92) begin
			put_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(sb.lim_ent) + $urandom_range(1, 3));
			repeat ($urandom_range(0, 8)) acl_bytes.push_back(8'($urandom));
			return;
		end
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
		if (n > sb.lim_ent && $urandom_range(0, 3) != 0)
			n = sb.lim_ent;
		bad_j = (shape >= 70 && shape < 80) ? $urandom_range(0, (n > 0) ? n - 1 : 0) : -1;
		big_j = (shape >= 80 && shape < 86) ? $urandom_range(0, (n > 0) ? n - 1 : 0) : -1;
		wide = ($urandom_range(0, 9) == 0) ? 48 : 12;
		if (wide > sb.lim_who)
			wide = sb.lim_who;
		put_word(n);
		for (int j = 0; j < n; j++) begin
			t = (j == bad_j) ? $urandom_range(32'hFFFF_FFFF, 4) : $urandom_range(0, TYPE_MAX);
			if (j == big_j) begin
				wl = 32'(sb.lim_who) + $urandom_range(1, 3);
				body = 4;
			end else begin
				wl = $urandom_range(0, wide);
				body = wl;
			end
			put_entry(t, rand_word(), rand_word(), wl, body);
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) acl_bytes.push_back(8'($urandom));
		if (shape >= 92 && acl_bytes.size() > 0) begin
			cut = $urandom_range(0, acl_bytes.size() - 1);
			while (acl_bytes.size() > cut)
				void'(acl_bytes.pop_back());
		end
	endfunction

	task automatic send_item(logic [7:0] b, logic present, logic fin);
		data_byte <= b;
		byte_present <= present;
		end_of_buffer <= fin;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		if (present || fin)
			items_sent++;
	endtask

	task automatic maybe_gap();
		if (!quiet && in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_acl(bit bare_end);
		int last;
		last = acl_bytes.size() - 1;
		case ($urandom_range(0, 3))
			0: in_gap_odds = 0;
			1: in_gap_odds = 3;
			2: in_gap_odds = 8;
			default: in_gap_odds = 24;
		endcase
		for (int i = 0; i <= last; i++) begin
			maybe_gap();
			if ($urandom_range(0, 39) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(acl_bytes[i], 1'b1, !bare_end && i == last);
		end
		if (bare_end || last < 0) begin
			maybe_gap();
			send_item(8'($urandom), 1'b0, 1'b1);
		end
		bytes_sent += acl_bytes.size();
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (sb.due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic program_limits(logic [16:0] buf_lim, logic [16:0] ent_lim,
		logic [16:0] who_lim, bit poke_unused);
		logic [1:0]  idx_list[4];
		logic [16:0] val_list[4];
		int          cnt;
		wait_results_done();
		idx_list[0] = REG_MAX_BUFFER;
		val_list[0] = buf_lim;
		idx_list[1] = REG_MAX_ENTRIES;
		val_list[1] = ent_lim;
		idx_list[2] = REG_MAX_WHO;
		val_list[2] = who_lim;
		idx_list[3] = REG_UNUSED;
		val_list[3] = 17'($urandom);
		cnt = poke_unused ? 4 : 3;
		for (int i = 0; i < cnt; i++) begin
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (cfg_ready !== 1'b1);
			sb.set_limit(idx_list[i], val_list[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_random_phase(int byte_budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < byte_budget) begin
			make_random_acl();
			send_acl($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 39) == 0)
				wait_results_done();
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default limits: short buffers, header extremes, entry-count, name-length, type and truncation errors
		acl_bytes.delete();
		send_acl(1'b1);
		acl_bytes.delete();
		acl_bytes.push_back(8'h00);
		acl_bytes.push_back(8'hFF);
		acl_bytes.push_back(8'h00);
		send_acl(1'b0);
		begin_acl(0);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(0, 0, 0, 0, 0);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(TYPE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 5);
		send_acl(1'b0);
		begin_acl(2);
		put_entry(1, $urandom, $urandom, 4, 4);
		put_entry(2, $urandom, $urandom, 1, 1);
		repeat (3) acl_bytes.push_back(8'($urandom));
		send_acl(1'b1);
		begin_acl(2);
		put_entry(TYPE_MAX + 1, $urandom, $urandom, 2, 2);
		put_entry(0, 0, 0, 0, 0);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(32'hFFFF_FFFF, 0, 0, 0, 0);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(0, $urandom, $urandom, 9, 9);
		repeat (5) void'(acl_bytes.pop_back());
		send_acl(1'b0);
		begin_acl(32'hFFFF_FFFF);
		send_acl(1'b0);
		begin_acl(1025);
		send_acl(1'b0);
		begin_acl(1024);
		acl_bytes.push_back(8'hFF);
		acl_bytes.push_back(8'h00);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(0, 0, 0, 1025, 4);
		send_acl(1'b0);

		// smallest limits
		program_limits(17'd4, 17'd0, 17'd0, 1'b1);
		begin_acl(0);
		send_acl(1'b0);
		begin_acl(0);
		acl_bytes.push_back(8'($urandom));
		send_acl(1'b0);
		begin_acl(1);
		send_acl(1'b0);

		program_limits(17'd20, 17'd1, 17'd0, 1'b0);
		begin_acl(1);
		put_entry(2, $urandom, $urandom, 0, 0);
		send_acl(1'b0);
		begin_acl(1);
		put_entry(0, $urandom, $urandom, 1, 0);
		send_acl(1'b0);

		program_limits(17'h1FFFF, 17'd2047, 17'd2047, 1'b0);
		run_random_phase(200);
		program_limits(17'($urandom_range(24, 96)), 17'd2, 17'd8, 1'b0);
		run_random_phase(160);
		program_limits(17'($urandom_range(4, 400)),
			17'(($urandom & 32'h1F800) | $urandom_range(0, 5)),
			17'(($urandom & 32'h1F800) | $urandom_range(0, 20)), 1'b1);
		run_random_phase(160);
		quiet = 1'b1;
		program_limits(17'd65536, 17'd1024, 17'd1024, 1'b0);
		run_random_phase(200);

		wait_results_done();
		repeat (END_PAD) @(posedge clk);
		$display("%0d buffers, %0d beats checked; status ok %0d, malformed %0d, overflow %0d",
			sb.buffers, sb.beats_checked, sb.st_count[ST_OK], sb.st_count[ST_MALFORMED],
			sb.st_count[ST_OVERFLOW]);
		$display("%0d limit settings, %0d input items, %0d mismatches",
			settings, items_sent, sb.mismatches);
		if (sb.mismatches == 0 && sb.due_beats.size() == 0)
			$display("nfs4_acl_xdr_parser test passed");
		else
			$display("nfs4_acl_xdr_parser test failed");
		$finish;
	end

endmodule
